// File: design/acpi_rsdp_scanner_macros.svh
// Assertion helpers used by the scan core.
`ifndef ACPI_RSDP_SCANNER_MACROS_SVH
`define ACPI_RSDP_SCANNER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define RSDP_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define RSDP_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/rsdp_pkg.sv
`default_nettype none

package rsdp_pkg;

    // Slot pitch at which the signature is probed
    localparam int unsigned SLOT_BYTES = 16;

    // Structure byte offsets
    localparam logic [31:0] OFS_SIG_LAST = 32'd7;
    localparam logic [31:0] OFS_STRUCT   = 32'd8;
    localparam logic [31:0] OFS_REV      = 32'd15;
    localparam logic [31:0] OFS_V1_END   = 32'd19;
    localparam logic [31:0] OFS_LEN_LAST = 32'd23;
    localparam logic [31:0] OFS_PREFIX   = 32'd24;
    localparam logic [31:0] OFS_V2_END   = 32'd31;
    localparam logic [31:0] OFS_SLOT_END = 32'(SLOT_BYTES - 1);

    // Number of stored prefix sums
    localparam int unsigned PREFIX_DEPTH = 24;
    localparam int unsigned PREFIX_AW    = $clog2(PREFIX_DEPTH);

    typedef enum logic [1:0] {
        ST_FOUND   = 2'd0,
        ST_NO_SIG  = 2'd1,
        ST_BAD_SUM = 2'd2,
        ST_TRUNC   = 2'd3
    } t_status;

    typedef enum logic {
        TT_RSDT = 1'b0,
        TT_XSDT = 1'b1
    } t_table_type;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_byte;
        logic       last_byte;
    } t_in_beat;

    typedef struct packed {
        t_status     status;
        t_table_type table_type;
        logic [63:0] location;
    } t_out_beat;

    // Handshake between the scan core and the result stage
    typedef struct packed {
        logic adv;
        logic emit;
    } t_step_ctl;

    // Signature "RSD PTR ", byte by byte
    function automatic logic [7:0] sig_byte(input logic [2:0] idx);
        logic [7:0] b;
        unique case (idx)
            3'd0:    b = 8'h52;
            3'd1:    b = 8'h53;
            3'd2:    b = 8'h44;
            3'd3:    b = 8'h20;
            3'd4:    b = 8'h50;
            3'd5:    b = 8'h54;
            3'd6:    b = 8'h52;
            default: b = 8'h20;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

// File: design/rsdp_in_stage.sv
`default_nettype none

module rsdp_in_stage import rsdp_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_ready,
    input  wire t_in_beat i_in_data,
    input  wire logic     i_pop,
    output logic          o_valid,
    output t_in_beat      o_data
);

    logic     r_valid;
    t_in_beat r_data;

    assign o_in_ready = !r_valid || i_pop;
    assign o_valid    = r_valid;
    assign o_data     = r_data;

    // Hold one beat until the core consumes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_data <= i_in_data;
        end
    end

endmodule

`default_nettype wire

// File: design/rsdp_scan_core.sv
`default_nettype none
`include "acpi_rsdp_scanner_macros.svh"

module rsdp_scan_core import rsdp_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_valid,
    input  wire t_in_beat i_data,
    input  wire logic     i_out_free,
    output logic          o_pop,
    output t_step_ctl     o_ctl,
    output t_out_beat     o_res
);

    typedef enum logic [1:0] {
        PH_SEEK,
        PH_READ,
        PH_DONE
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [31:0] r_offset, n_offset;
    logic        r_rej, n_rej;
    logic [7:0]  r_sum, n_sum;
    logic [7:0]  r_rev;
    logic [31:0] r_len;
    logic [31:0] r_short;
    logic [63:0] r_long;
    logic [7:0]  r_prefix [PREFIX_DEPTH];

    logic                adv;
    logic [7:0]          d;
    t_phase              cur_phase;
    logic [31:0]         cur_off;
    logic                cur_rej;
    logic [7:0]          cur_sum;
    logic [7:0]          sum_add;
    logic                rej_hit;
    logic [31:0]         len_full;
    logic [31:0]         short_full;
    logic [63:0]         long_full;
    logic [PREFIX_AW-1:0] pre_idx;
    logic [7:0]          pre_val;
    logic [7:0]          sum_read;
    logic [7:0]          sum_fix;
    logic [32:0]         off_next;
    logic                emit;
    t_out_beat           res;

    assign adv   = i_valid && i_out_free;
    assign o_pop = adv;
    assign d     = i_data.data_byte;

    // Restart on a first byte: view the state as freshly cleared
    assign cur_phase = i_data.first_byte ? PH_SEEK : r_phase;
    assign cur_off   = i_data.first_byte ? '0 : r_offset;
    assign cur_rej   = i_data.first_byte ? 1'b0 : r_rej;
    assign cur_sum   = i_data.first_byte ? '0 : r_sum;

    assign sum_add  = cur_sum + d;
    assign rej_hit  = cur_rej || ((cur_off < OFS_STRUCT) && (d != sig_byte(cur_off[2:0])));
    assign off_next = {1'b0, cur_off} + 33'd1;

    // Complete multi-byte fields with the byte in flight
    assign len_full   = {d, r_len[23:0]};
    assign short_full = {d, r_short[23:0]};
    assign long_full  = (cur_off == OFS_V2_END) ? {d, r_long[55:0]} : r_long;

    // Prefix sum for short revision-2 structures; entry 23 is the live sum
    assign pre_idx = len_full[PREFIX_AW-1:0];
    assign pre_val = (len_full == OFS_LEN_LAST) ? cur_sum : r_prefix[pre_idx];

    assign sum_read = ((cur_off < OFS_PREFIX) || (cur_off < r_len)) ? sum_add : cur_sum;
    assign sum_fix  = ((cur_off == OFS_LEN_LAST) && (r_rev != 8'd0) && (len_full < OFS_PREFIX))
                      ? pre_val : sum_read;

    // Next state and result for one byte
    always_comb begin
        n_phase  = cur_phase;
        n_offset = cur_off;
        n_rej    = cur_rej;
        n_sum    = cur_sum;
        emit     = 1'b0;
        res      = '{status: ST_FOUND, table_type: TT_RSDT, location: '0};
        unique case (cur_phase)
            PH_SEEK: begin
                n_sum = sum_add;
                n_rej = rej_hit;
                if (!rej_hit && (cur_off == OFS_SIG_LAST)) begin
                    n_phase  = PH_READ;
                    n_offset = OFS_STRUCT;
                    if (i_data.last_byte) begin
                        emit       = 1'b1;
                        res.status = ST_TRUNC;
                    end
                end else begin
                    if (cur_off >= OFS_SLOT_END) begin
                        n_offset = '0;
                        n_rej    = 1'b0;
                        n_sum    = '0;
                    end else begin
                        n_offset = off_next[31:0];
                    end
                    if (i_data.last_byte) begin
                        emit       = 1'b1;
                        res.status = ST_NO_SIG;
                    end
                end
            end
            PH_READ: begin
                n_sum = sum_fix;
                if ((cur_off == OFS_V1_END) && (r_rev == 8'd0)) begin
                    emit = 1'b1;
                    if (sum_fix != 8'd0) begin
                        res.status = ST_BAD_SUM;
                    end else begin
                        res.location = {32'd0, short_full};
                    end
                end else if ((cur_off >= OFS_V2_END) && (r_rev != 8'd0)
                             && (off_next >= {1'b0, r_len})) begin
                    emit           = 1'b1;
                    res.table_type = TT_XSDT;
                    if (sum_fix != 8'd0) begin
                        res.status = ST_BAD_SUM;
                    end else begin
                        res.location = long_full;
                    end
                end else if (i_data.last_byte) begin
                    emit       = 1'b1;
                    res.status = ST_TRUNC;
                end else begin
                    n_offset = off_next[31:0];
                end
            end
            default: begin
                n_phase = PH_DONE;
            end
        endcase
        if (emit) begin
            n_phase = PH_DONE;
        end
    end

    assign o_ctl = '{adv: adv, emit: emit};
    assign o_res = res;

    // Hold scan state, advance once per consumed beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_SEEK;
            r_offset <= '0;
            r_rej    <= 1'b0;
            r_sum    <= '0;
        end else if (adv) begin
            r_phase  <= n_phase;
            r_offset <= n_offset;
            r_rej    <= n_rej;
            r_sum    <= n_sum;
        end
    end

    // Capture structure fields and prefix sums
    always_ff @(posedge i_clk) begin
        if (adv && (cur_phase != PH_DONE)) begin
            if (cur_off < OFS_PREFIX) begin
                r_prefix[cur_off[PREFIX_AW-1:0]] <= cur_sum;
            end
            if (cur_phase == PH_READ) begin
                if (cur_off == OFS_REV) begin
                    r_rev <= d;
                end else if ((cur_off >= 32'd16) && (cur_off <= OFS_V1_END)) begin
                    r_short[8*cur_off[1:0] +: 8] <= d;
                end else if ((cur_off >= 32'd20) && (cur_off <= OFS_LEN_LAST)) begin
                    r_len[8*cur_off[1:0] +: 8] <= d;
                end else if ((cur_off >= OFS_PREFIX) && (cur_off <= OFS_V2_END)) begin
                    r_long[8*cur_off[2:0] +: 8] <= d;
                end
            end
        end
    end

    `RSDP_ASSERT_IMP(a_loc_zero, i_clk, i_rst_n, emit && (res.status != ST_FOUND), res.location == 64'd0, "location set on a failed result")
    `RSDP_ASSERT_NXT(a_done_after_emit, i_clk, i_rst_n, adv && emit, r_phase == PH_DONE, "scan not parked after a result")
    `RSDP_ASSERT_IMP(a_read_offset, i_clk, i_rst_n, r_phase == PH_READ, r_offset >= OFS_STRUCT, "structure read below signature end")
    `RSDP_ASSERT_IMP(a_seek_offset, i_clk, i_rst_n, r_phase == PH_SEEK, r_offset <= OFS_SLOT_END, "seek offset past slot end")

endmodule

`default_nettype wire

// File: design/rsdp_out_stage.sv
`default_nettype none

module rsdp_out_stage import rsdp_pkg::*; (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_step_ctl i_ctl,
    input  wire t_out_beat i_res,
    output logic           o_free,
    output logic           o_out_valid,
    input  wire logic      i_out_ready,
    output t_out_beat      o_out_data
);

    logic      r_valid;
    t_out_beat r_data;

    assign o_free      = !r_valid || i_out_ready;
    assign o_out_valid = r_valid;
    assign o_out_data  = r_data;

    // Load a result, drop it once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctl.adv && i_ctl.emit) begin
            r_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.adv && i_ctl.emit) begin
            r_data <= i_res;
        end
    end

endmodule

`default_nettype wire

// File: design/acpi_rsdp_scanner.sv
// RSDP signature search and checksum over a byte stream.
// Input channel: one memory byte per beat (i_in_valid / o_in_ready, payload
// i_in_data) with first_byte marking a region start and last_byte its end.
// Each slot start is probed for "RSD PTR "; a matching slot is parsed as a
// root pointer and its byte sum checked (20 bytes for revision 0, otherwise
// the stated length, reading at least through byte 31).
// Output channel: at most one result beat per region (o_out_valid /
// i_out_ready, payload o_out_data) with status, table type and address.
// Throughput: one byte per cycle unless the receiver stalls; the input
// register, combinational scan logic and the result register form a
// two-stage path; a result shows on o_out_valid from the result register.
// After a result, bytes are taken and dropped until the next first byte.
// Reset clears the handshake registers and starts a new search; the first
// byte after reset opens a region even without first_byte.
// When the receiver stalls, the result register holds its beat, the input
// register fills, and o_in_ready falls until the result is taken.
`default_nettype none

module acpi_rsdp_scanner import rsdp_pkg::*; (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_ready,
    input  wire t_in_beat  i_in_data,
    output logic           o_out_valid,
    input  wire logic      i_out_ready,
    output t_out_beat      o_out_data
);

    logic      pop;
    logic      in_valid;
    t_in_beat  in_data;
    logic      out_free;
    t_step_ctl step_ctl;
    t_out_beat res;

    rsdp_in_stage u_in (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .i_pop      (pop),
        .o_valid    (in_valid),
        .o_data     (in_data)
    );

    rsdp_scan_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (in_valid),
        .i_data     (in_data),
        .i_out_free (out_free),
        .o_pop      (pop),
        .o_ctl      (step_ctl),
        .o_res      (res)
    );

    rsdp_out_stage u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (step_ctl),
        .i_res       (res),
        .o_free      (out_free),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire
